// ===== rtl/core/bvls_pkg.sv =====
// Shared types and constants for the bus voltage loop with soft start.
package bvls_pkg;

    // Configuration register indices
    localparam logic [2:0] CFG_COEF_NOW      = 3'd0;
    localparam logic [2:0] CFG_COEF_PREV     = 3'd1;
    localparam logic [2:0] CFG_COEF_PREV_TWO = 3'd2;
    localparam logic [2:0] CFG_FAST_LIMIT    = 3'd3;
    localparam logic [2:0] CFG_FINAL_TARGET  = 3'd4;
    localparam logic [2:0] CFG_BOOST_THR     = 3'd5;
    localparam logic [2:0] CFG_RAMP_PERIOD   = 3'd6;
    localparam logic [2:0] CFG_OUTPUT_MAX    = 3'd7;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;

    // Reset values
    localparam logic signed [15:0] RST_COEF_NOW      = 16'sd3600;
    localparam logic signed [15:0] RST_COEF_PREV     = -16'sd3400;
    localparam logic signed [15:0] RST_COEF_PREV_TWO = 16'sd0;
    localparam logic [15:0]        RST_FAST_LIMIT    = 16'd3500;
    localparam logic [15:0]        RST_FINAL_TARGET  = 16'd3800;
    localparam logic [14:0]        RST_BOOST_THR     = 15'd300;
    localparam logic [7:0]         RST_RAMP_PERIOD   = 8'd150;
    localparam logic [30:0]        RST_OUTPUT_MAX    = 31'd2146304000;

    // Fast ramp step size
    localparam logic [16:0] FAST_STEP = 17'd5;

    typedef struct packed {
        logic signed [15:0] coef_now;
        logic signed [15:0] coef_prev;
        logic signed [15:0] coef_prev_two;
        logic [15:0]        fast_ramp_limit;
        logic [15:0]        final_target;
        logic [14:0]        error_boost_threshold;
        logic [7:0]         ramp_period;
        logic [30:0]        output_max;
    } t_cfg;

    // Multiplier operand pair select
    typedef enum logic [1:0] {
        MUL_NOW,
        MUL_PREV,
        MUL_PREV_TWO
    } t_mul_sel;

    typedef struct packed {
        logic     load;      // latch input word
        logic     ramp;      // soft-start reference update
        logic     err;       // form and scale the error
        logic     mul_en;    // register one product
        t_mul_sel mul_sel;
        logic     sum_init;  // preload sum with accumulator
        logic     sum_add;   // add previous product (x2) into sum
        logic     commit;    // clamp, update history, load output word
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;      // output register can take a word this cycle
    } t_dp_sts;

endpackage

// ===== rtl/core/bvls_regs.sv =====
// Configuration register file for the bus voltage loop.
module bvls_regs
    import bvls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_now              <= RST_COEF_NOW;
            r_cfg.coef_prev             <= RST_COEF_PREV;
            r_cfg.coef_prev_two         <= RST_COEF_PREV_TWO;
            r_cfg.fast_ramp_limit       <= RST_FAST_LIMIT;
            r_cfg.final_target          <= RST_FINAL_TARGET;
            r_cfg.error_boost_threshold <= RST_BOOST_THR;
            r_cfg.ramp_period           <= RST_RAMP_PERIOD;
            r_cfg.output_max            <= RST_OUTPUT_MAX;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_COEF_NOW:      r_cfg.coef_now              <= i_cfg_wdata[15:0];
                CFG_COEF_PREV:     r_cfg.coef_prev             <= i_cfg_wdata[15:0];
                CFG_COEF_PREV_TWO: r_cfg.coef_prev_two         <= i_cfg_wdata[15:0];
                CFG_FAST_LIMIT:    r_cfg.fast_ramp_limit       <= i_cfg_wdata[15:0];
                CFG_FINAL_TARGET:  r_cfg.final_target          <= i_cfg_wdata[15:0];
                CFG_BOOST_THR:     r_cfg.error_boost_threshold <= i_cfg_wdata[14:0];
                CFG_RAMP_PERIOD:   r_cfg.ramp_period           <= i_cfg_wdata[7:0];
                CFG_OUTPUT_MAX:    r_cfg.output_max            <= i_cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/bvls_ctrl.sv =====
// Sequencer for one control tick: ramp, error, three MACs, clamp and hand-off.
module bvls_ctrl
    import bvls_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REF,
        S_ERR,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_ADD,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REF;
                end
            end
            S_REF: begin
                o_cmd.ramp = 1'b1;
                n_state    = S_ERR;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_NOW;
                o_cmd.sum_init = 1'b1;
                n_state        = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PREV;
                o_cmd.sum_add = 1'b1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PREV_TWO;
                o_cmd.sum_add = 1'b1;
                n_state       = S_ADD;
            end
            S_ADD: begin
                o_cmd.sum_add = 1'b1;
                n_state       = S_COMMIT;
            end
            S_COMMIT: begin
                // hold here until the output register has room
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/core/bvls_dp.sv =====
// Datapath: soft-start reference, error scaling, shared multiplier, clamp, output word.
module bvls_dp
    import bvls_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [15:0]        i_bus_voltage,
    input  logic               i_ac_undervoltage,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [14:0]        o_current_reference,
    output logic signed [15:0] o_voltage_error,
    output logic [15:0]        o_bus_reference_out
);

    logic [15:0]        r_bus;
    logic               r_uv;
    logic [15:0]        r_ref;
    logic [7:0]         r_cnt;
    logic signed [15:0] r_err;
    logic signed [15:0] r_err_last;
    logic signed [15:0] r_err_blast;
    logic [30:0]        r_acc;
    logic signed [31:0] r_prod;
    logic signed [35:0] r_sum;
    logic               r_out_valid;
    logic [14:0]        r_out_cref;
    logic signed [15:0] r_out_err;
    logic [15:0]        r_out_ref;

    // ramp
    logic [16:0] ref_plus5;
    logic [15:0] ref_fast;
    logic [15:0] n_ref;
    logic [7:0]  n_cnt;

    always_comb begin
        ref_plus5 = {1'b0, r_ref} + FAST_STEP;
        ref_fast  = ref_plus5[16] ? 16'hFFFF : ref_plus5[15:0];
        n_ref     = r_ref;
        n_cnt     = r_cnt;
        if (r_uv) begin
            n_ref = r_bus;
        end else if (r_cnt > i_cfg.ramp_period) begin
            n_cnt = '0;
            if (r_ref < i_cfg.fast_ramp_limit) begin
                n_ref = ref_fast;
            end else if (r_ref < i_cfg.final_target) begin
                n_ref = r_ref + 16'd1;
            end else begin
                n_ref = i_cfg.final_target;
            end
        end else begin
            n_cnt = r_cnt + 8'd1;
        end
    end

    // error and boost
    logic signed [15:0] err_raw;
    logic signed [16:0] err_wide;
    logic signed [16:0] thr_pos;
    logic signed [16:0] thr_neg;
    logic signed [15:0] err_x3;
    logic signed [15:0] n_err;

    always_comb begin
        err_raw  = $signed(r_ref - r_bus);
        err_wide = {err_raw[15], err_raw};
        thr_pos  = $signed({2'b00, i_cfg.error_boost_threshold});
        thr_neg  = -thr_pos;
        err_x3   = err_raw + $signed({err_raw[14:0], 1'b0});
        n_err    = ((err_wide > thr_pos) || (err_wide < thr_neg)) ? err_x3 : err_raw;
    end

    // shared 16x16 multiplier
    logic signed [15:0] mul_a;
    logic signed [15:0] mul_b;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_NOW: begin
                mul_a = i_cfg.coef_now;
                mul_b = r_err;
            end
            MUL_PREV: begin
                mul_a = i_cfg.coef_prev;
                mul_b = r_err_last;
            end
            MUL_PREV_TWO: begin
                mul_a = i_cfg.coef_prev_two;
                mul_b = r_err_blast;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product doubled and sign-extended to the sum width
    logic signed [35:0] prod_x2;
    logic signed [35:0] acc_max;
    logic [30:0]        acc_clamp;

    always_comb begin
        prod_x2 = {{3{r_prod[31]}}, r_prod, 1'b0};
        acc_max = $signed({5'b0, i_cfg.output_max});
        if (r_sum[35]) begin
            acc_clamp = '0;
        end else if (r_sum > acc_max) begin
            acc_clamp = i_cfg.output_max;
        end else begin
            acc_clamp = r_sum[30:0];
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref       <= '0;
            r_cnt       <= '0;
            r_err_last  <= '0;
            r_err_blast <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ramp) begin
                r_ref <= n_ref;
                r_cnt <= n_cnt;
            end
            if (i_cmd.commit) begin
                r_acc       <= acc_clamp;
                r_err_last  <= r_err;
                r_err_blast <= r_err_last;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bus <= i_bus_voltage;
            r_uv  <= i_ac_undervoltage;
        end
        if (i_cmd.err) begin
            r_err <= n_err;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.sum_init) begin
            r_sum <= $signed({5'b0, r_acc});
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + prod_x2;
        end
        if (i_cmd.commit) begin
            r_out_cref <= acc_clamp[30:16];
            r_out_err  <= r_err;
            r_out_ref  <= r_ref;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_current_reference = r_out_cref;
    assign o_voltage_error     = r_out_err;
    assign o_bus_reference_out = r_out_ref;

endmodule

// ===== rtl/core/bus_voltage_loop_soft_start_core.sv =====
// Top level of the DC bus voltage loop with soft start.
// One word in per control tick: bus voltage plus AC undervoltage flag. The core
// steps the soft-start reference (or tracks the bus under undervoltage), forms
// reference minus bus, triples it when its magnitude exceeds the boost
// threshold, runs a three-tap incremental compensator on one shared 16x16
// multiplier and clamps the accumulator to [0, output_max]. One result word per
// input word: current reference (accumulator bits 30..16), scaled error and
// present bus reference. Sequence: a word is latched at its accepting edge, then
// passes through ramp, error, three multiplier passes, final add and
// clamp/commit, where the result is registered; the next word can be taken
// once the core is idle again. The three products share the single multiplier,
// so they are formed one after another. Input stall is high from acceptance
// until commit; a finished word waits in the output register while the next
// input is taken, and commit holds off only if that register is still
// occupied. Configuration writes are registered and are expected only while
// the core is idle.
module bus_voltage_loop_soft_start_core
    import bvls_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input word
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [15:0]           i_bus_voltage,
    input  logic                  i_ac_undervoltage,
    // result word
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [14:0]           o_current_reference,
    output logic signed [15:0]    o_voltage_error,
    output logic [15:0]           o_bus_reference_out
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    busy;

    bvls_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bvls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    bvls_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_bus_voltage       (i_bus_voltage),
        .i_ac_undervoltage   (i_ac_undervoltage),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_current_reference (o_current_reference),
        .o_voltage_error     (o_voltage_error),
        .o_bus_reference_out (o_bus_reference_out)
    );

    // busy from acceptance until the tick commits
    assign o_in_stall = busy;

`ifndef NO_ASSERTIONS
    // a commit never overwrites a word still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !cmd.commit)
        else $error("commit while output word pending");

    // taking a word makes the core busy on the next cycle
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("core not busy after accepting a word");

    // a new result only appears through a commit
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.commit))
        else $error("output valid without commit");

    // commit only happens while busy, never alongside a load
    a_commit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (busy && !cmd.load))
        else $error("commit outside a tick");
`endif

endmodule
